[rtl/core/complex_to_color_index_defines.svh]
// assertion macros for the complex to color index block
`ifndef COMPLEX_TO_COLOR_INDEX_DEFINES_SVH
`define COMPLEX_TO_COLOR_INDEX_DEFINES_SVH

`ifndef SYNTHESIS

`define CTI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CTI_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTI_ASSERT(label, clk, rst, prop, msg)

`define CTI_ASSERT_NORST(label, clk, prop, msg)

`endif

`endif

[rtl/core/cti_pkg.sv]
// types, constants and tables shared by the complex to color index block
`timescale 1ns / 1ps

package cti_pkg;

  localparam int SAMPLE_BITS           = 16;
  localparam int CORDIC_ITERATIONS_DEF = 16;

  // cordic datapath: samples scaled by 2^SCALE_SHIFT, values stay below 2^61
  localparam int SCALE_SHIFT = 60 - SAMPLE_BITS;
  localparam int CORDIC_W    = 62;
  localparam int ACC_W       = 32;
  localparam int TURN_W      = 32;

  // intensity search
  localparam int LEVEL_W = 9;
  localparam int MAG_W   = 2 * SAMPLE_BITS;
  localparam int R2_W    = 32;
  localparam int P_W     = R2_W + LEVEL_W;
  localparam int Q_W     = 52;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGNITUDE_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTENSITY_LEVELS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_LEVELS     = 2'd2;

  localparam logic [15:0]        MAGNITUDE_LIMIT_RST  = 16'd32768;
  localparam logic [LEVEL_W-1:0] INTENSITY_LEVELS_RST = 9'd16;
  localparam logic [LEVEL_W-1:0] PHASE_LEVELS_RST     = 9'd16;

  // atan(2^-i) in turns * 2^32
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  localparam logic signed [ACC_W-1:0] ANGLE_MIN = 32'sd1;
  localparam logic signed [ACC_W-1:0] ANGLE_MAX = 32'sh3FFF_FFFF;

  localparam logic [TURN_W-1:0] TURN_QUARTER       = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_HALF          = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_THREE_QUARTER = 32'hC000_0000;

  typedef enum logic [2:0] {
    PH_ZERO,
    PH_HALF,
    PH_QUARTER,
    PH_THREE_QUARTER,
    PH_Q1,
    PH_Q2,
    PH_Q3,
    PH_Q4
  } phase_class_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] real_part;
    logic signed [SAMPLE_BITS-1:0] imag_part;
  } sample_t;

  typedef struct packed {
    logic [15:0] palette_index;
    logic [7:0]  intensity_level;
    logic [7:0]  phase_level;
  } color_t;

endpackage

[rtl/core/complex_to_color_index.sv]
// top level: complex sample to domain coloring palette index
//
//   channel   direction  handshake                         payload
//   sample    in         sample_valid / sample_stall       cti_pkg::sample_t
//   color     out        color_valid / color_stall         cti_pkg::color_t
//   cfg       in         cfg_write_enable, cfg_index       cfg_write_data
//
// one transaction per cycle while the skid register is empty; a result's latency is
// set by the longer of the cordic cell row and the intensity search row
// synchronous reset clears the pipeline valid bits, the output slot valid bits and the
// configuration registers; no clearing pass
// a stalled result waits in the output register while one more goes to the skid
// register; sample_stall is high only while the skid register is full
`timescale 1ns / 1ps
`include "complex_to_color_index_defines.svh"

module complex_to_color_index #(
  parameter int CORDIC_ITERATIONS = cti_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [cti_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cti_pkg::CFG_DATA_W-1:0]    cfg_write_data,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  cti_pkg::sample_t                  sample,
  output logic                              color_valid,
  input  logic                              color_stall,
  output cti_pkg::color_t                   color
);

  import cti_pkg::*;

  localparam int PH_LEN  = CORDIC_ITERATIONS + 2;
  localparam int MAG_LEN = LEVEL_W + 3;
  localparam int L       = (PH_LEN > MAG_LEN) ? PH_LEN : MAG_LEN;
  localparam int PH_PAD  = L - PH_LEN;
  localparam int MAG_PAD = L - MAG_LEN;
  localparam int PC_W    = $bits(phase_class_t);

  // configuration
  logic [15:0]        magnitude_limit;
  logic [LEVEL_W-1:0] intensity_levels;
  logic [LEVEL_W-1:0] phase_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_limit  <= MAGNITUDE_LIMIT_RST;
      intensity_levels <= INTENSITY_LEVELS_RST;
      phase_levels     <= PHASE_LEVELS_RST;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_MAGNITUDE_LIMIT:  magnitude_limit  <= cfg_write_data;
        CFG_INTENSITY_LEVELS: intensity_levels <= cfg_write_data[LEVEL_W-1:0];
        CFG_PHASE_LEVELS:     phase_levels     <= cfg_write_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // derived configuration
  logic [LEVEL_W-1:0]   nint_eff_next;
  logic [LEVEL_W-1:0]   nint_m1_next;
  logic [LEVEL_W-1:0]   nint_eff;
  logic [LEVEL_W-1:0]   nint_m1;
  logic [2*LEVEL_W-1:0] nm1sq;
  logic [LEVEL_W-1:0]   nph_m1;
  logic [R2_W-1:0]      r2;
  logic                 rmax_zero;

  assign nint_eff_next = (intensity_levels == '0) ? LEVEL_W'(1) : intensity_levels;
  assign nint_m1_next  = nint_eff_next - LEVEL_W'(1);

  always_ff @(posedge clk) begin
    nint_eff  <= nint_eff_next;
    nint_m1   <= nint_m1_next;
    nm1sq     <= (2*LEVEL_W)'(nint_m1_next) * (2*LEVEL_W)'(nint_m1_next);
    nph_m1    <= (phase_levels == '0) ? '0 : phase_levels - LEVEL_W'(1);
    r2        <= R2_W'(magnitude_limit) * R2_W'(magnitude_limit);
    rmax_zero <= (magnitude_limit == '0);
  end

  // handshake and stage valids
  logic         en;
  logic         push;
  logic         pop;
  logic         skid_valid;
  logic [L:0]   stage_valid;

  assign en           = !skid_valid;
  assign sample_stall = skid_valid;
  assign push         = en && stage_valid[L];
  assign pop          = color_valid && !color_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[L-1:0], sample_valid};
    end
  end

  // front stage: magnitudes, squares, phase class
  logic [SAMPLE_BITS-1:0] ax_next;
  logic [SAMPLE_BITS-1:0] ay_next;
  logic                   re_neg;
  logic                   im_neg;
  phase_class_t           pc_next;

  logic [SAMPLE_BITS-1:0] f_ax;
  logic [SAMPLE_BITS-1:0] f_ay;
  logic [MAG_W-1:0]       f_axsq;
  logic [MAG_W-1:0]       f_aysq;
  phase_class_t           f_pc;

  assign re_neg  = sample.real_part[SAMPLE_BITS-1];
  assign im_neg  = sample.imag_part[SAMPLE_BITS-1];
  assign ax_next = re_neg ? $unsigned(-sample.real_part) : $unsigned(sample.real_part);
  assign ay_next = im_neg ? $unsigned(-sample.imag_part) : $unsigned(sample.imag_part);

  always_comb begin
    if (sample.imag_part == '0) begin
      pc_next = re_neg ? PH_HALF : PH_ZERO;
    end else if (sample.real_part == '0) begin
      pc_next = im_neg ? PH_THREE_QUARTER : PH_QUARTER;
    end else if (!re_neg && !im_neg) begin
      pc_next = PH_Q1;
    end else if (re_neg && !im_neg) begin
      pc_next = PH_Q2;
    end else if (re_neg) begin
      pc_next = PH_Q3;
    end else begin
      pc_next = PH_Q4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ax   <= ax_next;
      f_ay   <= ay_next;
      f_axsq <= MAG_W'(ax_next) * MAG_W'(ax_next);
      f_aysq <= MAG_W'(ay_next) * MAG_W'(ay_next);
      f_pc   <= pc_next;
    end
  end

  // phase path: cordic cell row
  logic signed [CORDIC_W-1:0] x_s   [CORDIC_ITERATIONS+1];
  logic signed [CORDIC_W-1:0] y_s   [CORDIC_ITERATIONS+1];
  logic signed [ACC_W-1:0]    acc_s [CORDIC_ITERATIONS+1];

  assign x_s[0] = $signed({{(CORDIC_W-SAMPLE_BITS-SCALE_SHIFT){1'b0}}, f_ax,
                           {SCALE_SHIFT{1'b0}}});
  assign y_s[0] = $signed({{(CORDIC_W-SAMPLE_BITS-SCALE_SHIFT){1'b0}}, f_ay,
                           {SCALE_SHIFT{1'b0}}});
  assign acc_s[0] = '0;

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
    cti_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .x_in    (x_s[g]),
      .y_in    (y_s[g]),
      .acc_in  (acc_s[g]),
      .x_out   (x_s[g+1]),
      .y_out   (y_s[g+1]),
      .acc_out (acc_s[g+1])
    );
  end

  logic [PC_W-1:0] pc_line_out;
  phase_class_t    pc_d;

  cti_delay #(
    .WIDTH (PC_W),
    .DEPTH (CORDIC_ITERATIONS)
  ) u_pc_line (
    .clk  (clk),
    .en   (en),
    .din  (f_pc),
    .dout (pc_line_out)
  );

  assign pc_d = phase_class_t'(pc_line_out);

  logic signed [ACC_W-1:0] angle_clamped;
  logic [TURN_W-1:0]       angle_u;
  logic [TURN_W-1:0]       turns_next;
  logic [TURN_W-1:0]       turns;

  always_comb begin
    if (acc_s[CORDIC_ITERATIONS] < ANGLE_MIN) begin
      angle_clamped = ANGLE_MIN;
    end else if (acc_s[CORDIC_ITERATIONS] > ANGLE_MAX) begin
      angle_clamped = ANGLE_MAX;
    end else begin
      angle_clamped = acc_s[CORDIC_ITERATIONS];
    end
    angle_u = $unsigned(angle_clamped);
    case (pc_d)
      PH_ZERO:          turns_next = '0;
      PH_HALF:          turns_next = TURN_HALF;
      PH_QUARTER:       turns_next = TURN_QUARTER;
      PH_THREE_QUARTER: turns_next = TURN_THREE_QUARTER;
      PH_Q1:            turns_next = angle_u;
      PH_Q2:            turns_next = TURN_HALF - angle_u;
      PH_Q3:            turns_next = TURN_HALF + angle_u;
      PH_Q4:            turns_next = '0 - angle_u;
      default:          turns_next = '0;
    endcase
  end

  logic [TURN_W+LEVEL_W-1:0] ip_prod;
  logic [LEVEL_W-1:0]        ip;

  assign ip_prod = (TURN_W+LEVEL_W)'(turns) * (TURN_W+LEVEL_W)'(nph_m1);

  always_ff @(posedge clk) begin
    if (en) begin
      turns <= turns_next;
      ip    <= ip_prod[TURN_W+LEVEL_W-1:TURN_W];
    end
  end

  // magnitude path: squared magnitude, search bound, level cell row
  logic [MAG_W-1:0]          m2;
  logic [MAG_W+2*LEVEL_W-1:0] rhs_prod;
  logic [Q_W-1:0]            rhs;
  logic                      m_ge;
  logic                      m_rz;

  assign rhs_prod = (MAG_W+2*LEVEL_W)'(m2) * (MAG_W+2*LEVEL_W)'(nm1sq);

  always_ff @(posedge clk) begin
    if (en) begin
      m2   <= f_axsq + f_aysq;
      rhs  <= Q_W'(rhs_prod);
      m_ge <= (R2_W'(m2) >= r2);
      m_rz <= rmax_zero;
    end
  end

  logic [Q_W-1:0]     rhs_s [LEVEL_W+1];
  logic [Q_W-1:0]     q_s   [LEVEL_W+1];
  logic [P_W-1:0]     p_s   [LEVEL_W+1];
  logic [LEVEL_W-1:0] k_s   [LEVEL_W+1];

  assign rhs_s[0] = rhs;
  assign q_s[0]   = '0;
  assign p_s[0]   = '0;
  assign k_s[0]   = '0;

  for (genvar g = 0; g < LEVEL_W; g++) begin : g_level
    cti_level_cell #(
      .BIT (LEVEL_W - 1 - g)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .r2      (r2),
      .rhs_in  (rhs_s[g]),
      .q_in    (q_s[g]),
      .p_in    (p_s[g]),
      .k_in    (k_s[g]),
      .rhs_out (rhs_s[g+1]),
      .q_out   (q_s[g+1]),
      .p_out   (p_s[g+1]),
      .k_out   (k_s[g+1])
    );
  end

  logic [1:0]         mflag_d;
  logic [LEVEL_W-1:0] ii_mag;

  cti_delay #(
    .WIDTH (2),
    .DEPTH (LEVEL_W)
  ) u_mflag_line (
    .clk  (clk),
    .en   (en),
    .din  ({m_rz, m_ge}),
    .dout (mflag_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      if (mflag_d[1]) begin
        ii_mag <= '0;
      end else if (mflag_d[0]) begin
        ii_mag <= nint_m1;
      end else begin
        ii_mag <= k_s[LEVEL_W];
      end
    end
  end

  // align both paths
  logic [LEVEL_W-1:0] ip_al;
  logic [LEVEL_W-1:0] ii_al;

  if (PH_PAD > 0) begin : g_ph_pad
    cti_delay #(
      .WIDTH (LEVEL_W),
      .DEPTH (PH_PAD)
    ) u_ip_pad (
      .clk  (clk),
      .en   (en),
      .din  (ip),
      .dout (ip_al)
    );
  end else begin : g_ph_direct
    assign ip_al = ip;
  end

  if (MAG_PAD > 0) begin : g_mag_pad
    cti_delay #(
      .WIDTH (LEVEL_W),
      .DEPTH (MAG_PAD)
    ) u_ii_pad (
      .clk  (clk),
      .en   (en),
      .din  (ii_mag),
      .dout (ii_al)
    );
  end else begin : g_mag_direct
    assign ii_al = ii_mag;
  end

  // result and output slots
  logic [2*LEVEL_W-1:0] palette_wide;
  color_t               result;
  color_t               skid;

  assign palette_wide           = (2*LEVEL_W)'(ip_al) * (2*LEVEL_W)'(nint_eff)
                                  + (2*LEVEL_W)'(ii_al);
  assign result.palette_index   = palette_wide[15:0];
  assign result.intensity_level = ii_al[7:0];
  assign result.phase_level     = ip_al[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        color_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        color_valid <= push;
      end
    end else if (push) begin
      if (!color_valid) begin
        color_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        color <= skid;
      end else if (push) begin
        color <= result;
      end
    end else if (push && !color_valid) begin
      color <= result;
    end
    if (push && color_valid && !pop) begin
      skid <= result;
    end
  end

  `CTI_ASSERT_NORST(a_reset_clears, clk, rst |=> (!color_valid && !skid_valid && stage_valid == '0), "reset left a transaction in flight")
  `CTI_ASSERT(a_skid_behind_out, clk, rst, !color_valid |-> !skid_valid, "skid register full while output empty")
  `CTI_ASSERT(a_skid_drains, clk, rst, (pop && skid_valid) |=> (color_valid && !skid_valid), "skid did not move to output")
  `CTI_ASSERT(a_empty_fill, clk, rst, (!color_valid && push) |=> (color_valid && !skid_valid), "result did not land in output register")
  `CTI_ASSERT(a_stall_to_skid, clk, rst, (color_valid && color_stall && push) |=> skid_valid, "result under stall not kept in skid")

endmodule

[rtl/core/cti_delay.sv]
// enabled shift register for side data that travels next to the cell rows and for path alignment
`timescale 1ns / 1ps

module cti_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int j = 1; j < DEPTH; j++) begin
        line[j] <= line[j-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

[rtl/core/cti_cordic_cell.sv]
// one vectoring cordic step with its own output register
`timescale 1ns / 1ps

module cti_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [cti_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [cti_pkg::CORDIC_W-1:0] y_in,
  input  logic signed [cti_pkg::ACC_W-1:0]    acc_in,
  output logic signed [cti_pkg::CORDIC_W-1:0] x_out,
  output logic signed [cti_pkg::CORDIC_W-1:0] y_out,
  output logic signed [cti_pkg::ACC_W-1:0]    acc_out
);

  import cti_pkg::*;

  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [ACC_W-1:0]    angle;

  // arithmetic shift floors toward minus infinity
  assign dx    = y_in >>> STEP;
  assign dy    = x_in >>> STEP;
  assign angle = $signed(ATAN_TURNS[STEP]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CORDIC_W-1]) begin
        x_out   <= x_in + dx;
        y_out   <= y_in - dy;
        acc_out <= acc_in + angle;
      end else begin
        x_out   <= x_in - dx;
        y_out   <= y_in + dy;
        acc_out <= acc_in - angle;
      end
    end
  end

endmodule

[rtl/core/cti_level_cell.sv]
// one bit of the intensity level search, squares kept by shift and add
`timescale 1ns / 1ps

module cti_level_cell #(
  parameter int BIT = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [cti_pkg::R2_W-1:0]        r2,
  input  logic [cti_pkg::Q_W-1:0]         rhs_in,
  input  logic [cti_pkg::Q_W-1:0]         q_in,
  input  logic [cti_pkg::P_W-1:0]         p_in,
  input  logic [cti_pkg::LEVEL_W-1:0]     k_in,
  output logic [cti_pkg::Q_W-1:0]         rhs_out,
  output logic [cti_pkg::Q_W-1:0]         q_out,
  output logic [cti_pkg::P_W-1:0]         p_out,
  output logic [cti_pkg::LEVEL_W-1:0]     k_out
);

  import cti_pkg::*;

  // q = k^2 * r2, p = k * r2; candidate adds 2^BIT to k
  logic [Q_W-1:0]     q_cand;
  logic [P_W-1:0]     p_cand;
  logic [LEVEL_W-1:0] k_bit;

  assign q_cand = q_in + (Q_W'(p_in) << (BIT + 1)) + (Q_W'(r2) << (2 * BIT));
  assign p_cand = p_in + (P_W'(r2) << BIT);
  assign k_bit  = LEVEL_W'(1) << BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      rhs_out <= rhs_in;
      if (q_cand <= rhs_in) begin
        q_out <= q_cand;
        p_out <= p_cand;
        k_out <= k_in | k_bit;
      end else begin
        q_out <= q_in;
        p_out <= p_in;
        k_out <= k_in;
      end
    end
  end

endmodule
